// ----- sv/coulomb_pair_energy_assert.svh -----
// Assertion macros used by the block's top module.
`ifndef COULOMB_PAIR_ENERGY_ASSERT_SVH
`define COULOMB_PAIR_ENERGY_ASSERT_SVH

// Implication checked every cycle outside reset.
`define CPE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define CPE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- sv/cpe_pkg.sv -----
package cpe_pkg;

  localparam int unsigned NumResiduesDef = 32;
  localparam int unsigned MaxAtomsDef    = 32;

  // Stage counts of the cell row.
  localparam int unsigned RootSteps = 18;   // root of a 36-bit value
  localparam int unsigned DivSteps  = 41;   // quotient bits 40 down to 0
  localparam int unsigned DivWidth  = 41;
  localparam int unsigned NumWidth  = 66;   // product N * scale
  localparam int unsigned RemWidth  = 42;

  localparam logic [40:0] QuotCap = 41'h100_0000_0000;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NOT_VALID = 2'd1,
    ERR_BAD_ARG   = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    CFG_COULOMB_K  = 3'd0,
    CFG_SCALE      = 3'd1,
    CFG_DIST_DEP   = 3'd2,
    CFG_DIELECTRIC = 3'd3,
    CFG_CUT_EN     = 3'd4,
    CFG_CUT_LIMIT  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic        req_type;
    logic [4:0]  res_a;
    logic [4:0]  atom_a;
    logic [4:0]  res_b;
    logic [4:0]  atom_b;
    logic signed [15:0] charge_value;
    logic [23:0] dist_sq;
    logic        solute;
    logic [15:0] item_dielectric;
  } req_t;

  typedef struct packed {
    logic signed [31:0] energy;
    logic [1:0]         error_code;
  } rsp_t;

  // Side data that rides along with an item through the cell rows.
  typedef struct packed {
    logic        vld;
    logic        done;        // result already decided (load or error)
    logic [1:0]  err;
    logic        neg;
    logic        clip;        // apply cutoff
    logic [30:0] limit;
  } tag_t;

  // One square-root cell: one result bit a step.
  typedef struct packed {
    logic [37:0] rem;
    logic [17:0] root;
    logic [35:0] val;
  } root_t;

  // One divide cell: one quotient bit a step.
  typedef struct packed {
    logic [NumWidth-1:0] num;
    logic [RemWidth-1:0] rem;
    logic [40:0]         quo;
    logic [DivWidth-1:0] div;
  } div_t;

endpackage

// ----- sv/cpe_root_cell.sv -----
module cpe_root_cell (
  input  logic            clk_i,
  input  cpe_pkg::root_t  in_i,
  input  logic [5:0]      pair_i,
  output cpe_pkg::root_t  out_o
);

  cpe_pkg::root_t step_d;
  logic [37:0] rem_sh;
  logic [37:0] trial;

  always_comb begin
    rem_sh = {in_i.rem[35:0], in_i.val[2*pair_i+1 -: 2]};
    trial  = {18'd0, in_i.root, 2'b01};
    step_d = in_i;
    if (rem_sh >= trial) begin
      step_d.rem  = rem_sh - trial;
      step_d.root = {in_i.root[16:0], 1'b1};
    end else begin
      step_d.rem  = rem_sh;
      step_d.root = {in_i.root[16:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    out_o <= step_d;
  end

endmodule

// ----- sv/cpe_div_cell.sv -----
module cpe_div_cell (
  input  logic           clk_i,
  input  cpe_pkg::div_t  in_i,
  input  logic [6:0]     bit_i,
  output cpe_pkg::div_t  out_o
);

  cpe_pkg::div_t step_d;
  logic [cpe_pkg::RemWidth-1:0] rem_sh;

  // Bits above 40 of the quotient are folded into the cap: the top numerator
  // bits are checked before the first cell; a capped quotient stays capped.
  always_comb begin
    step_d = in_i;
    rem_sh = {in_i.rem[cpe_pkg::RemWidth-2:0], in_i.num[bit_i]};
    if (rem_sh >= {1'b0, in_i.div}) begin
      step_d.rem = rem_sh - {1'b0, in_i.div};
      step_d.quo = {in_i.quo[39:0], 1'b1};
    end else begin
      step_d.rem = rem_sh;
      step_d.quo = {in_i.quo[39:0], 1'b0};
    end
    if (in_i.quo[40] || (in_i.quo >= cpe_pkg::QuotCap && in_i.quo != '0)) begin
      step_d.quo = cpe_pkg::QuotCap;
    end
  end

  always_ff @(posedge clk_i) begin
    out_o <= step_d;
  end

endmodule

// ----- sv/coulomb_pair_energy.sv -----
// Coulomb pair energy, one atom pair per cycle while busy is low.
// Items enter on start with req_i and are taken at any edge where busy is low.
// After reset busy stays high for one pass over the charge table
// (NumResidues * MaxAtoms entries, 1024 by default), while the entry
// valid flags are cleared; after that pass busy stays low for good.
// Each item gives one result on rsp_o, marked by done_o for one cycle, after
// passing 1 table read stage, 18 square-root cells, 3 divisor and product
// stages, 41 divide cells and 1 output stage.
// Throughput: one item per cycle, back to back, while not busy; every cell
// row takes a new item each cycle. The receiver cannot stall or hold results.
// Load items in range write the charge table at the front; all give energy 0.
// Configuration is written on cfg_valid_i/cfg_ready_o (ready is always high)
// and must only change while no item is in flight.
// Reset restores the register defaults and empties the pipeline; charge
// entries are cleared and marked not valid until loaded.
`include "coulomb_pair_energy_assert.svh"

module coulomb_pair_energy #(
  parameter int unsigned NumResidues = cpe_pkg::NumResiduesDef,
  parameter int unsigned MaxAtoms    = cpe_pkg::MaxAtomsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  cpe_pkg::req_t req_i,
  output logic          done_o,
  output cpe_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_wdata_i
);

  localparam int unsigned Depth = NumResidues * MaxAtoms;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RootLat = cpe_pkg::RootSteps;

  // ---------------- configuration
  logic [19:0] coulomb_k_q;
  logic [15:0] scale_q, diel_q;
  logic        dist_dep_q, cut_en_q;
  logic [30:0] cut_lim_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coulomb_k_q <= 20'd340029;
      scale_q     <= 16'd256;
      dist_dep_q  <= 1'b1;
      diel_q      <= 16'd3072;
      cut_en_q    <= 1'b1;
      cut_lim_q   <= 31'd655360;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cpe_pkg::CFG_COULOMB_K:  coulomb_k_q <= cfg_wdata_i[19:0];
        cpe_pkg::CFG_SCALE:      scale_q     <= cfg_wdata_i[15:0];
        cpe_pkg::CFG_DIST_DEP:   dist_dep_q  <= cfg_wdata_i[0];
        cpe_pkg::CFG_DIELECTRIC: diel_q      <= cfg_wdata_i[15:0];
        cpe_pkg::CFG_CUT_EN:     cut_en_q    <= cfg_wdata_i[0];
        cpe_pkg::CFG_CUT_LIMIT:  cut_lim_q   <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // ---------------- table clearing pass after reset
  logic             clr_q;
  logic [AddrW-1:0] clr_addr_q;

  assign busy = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == AddrW'(Depth - 1)) clr_q <= 1'b0;
      clr_addr_q <= clr_addr_q + AddrW'(1);
    end
  end

  // ---------------- stage 0: address, table access
  logic in_fire;
  logic ok_a, ok_b;
  logic [AddrW-1:0] addr_a, addr_b;
  assign in_fire = start && !busy;

  always_comb begin
    ok_a = ({27'd0, req_i.res_a} < 32'(NumResidues)) && ({27'd0, req_i.atom_a} < 32'(MaxAtoms));
    ok_b = ({27'd0, req_i.res_b} < 32'(NumResidues)) && ({27'd0, req_i.atom_b} < 32'(MaxAtoms));
    addr_a = AddrW'(32'(req_i.res_a) * 32'(MaxAtoms) + 32'(req_i.atom_a));
    addr_b = AddrW'(32'(req_i.res_b) * 32'(MaxAtoms) + 32'(req_i.atom_b));
  end

  // entry layout: {valid, charge}
  logic [16:0] mem_a [Depth];
  logic [16:0] mem_b [Depth];
  logic [16:0] ea_q, eb_q;
  logic        wr;
  assign wr = in_fire && !req_i.req_type && ok_a;

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_a[clr_addr_q] <= '0;
      mem_b[clr_addr_q] <= '0;
    end else if (wr) begin
      mem_a[addr_a] <= {1'b1, req_i.charge_value};
      mem_b[addr_a] <= {1'b1, req_i.charge_value};
    end
    ea_q <= mem_a[addr_a];
    eb_q <= mem_b[addr_b];
  end

  // Decide errors at entry; divisor selection kept with the item.
  cpe_pkg::tag_t t0_d, t1_q, t1_fix;
  logic [23:0] dsq1_q;
  logic [15:0] eps1_q;
  logic        ddm1_q;
  logic        pair1_q;
  logic [15:0] eps_sel;
  logic        ddm_sel;

  always_comb begin
    ddm_sel = !req_i.solute && dist_dep_q;
    eps_sel = req_i.solute ? req_i.item_dielectric : diel_q;
    t0_d       = '0;
    t0_d.vld   = in_fire;
    t0_d.clip  = !req_i.solute && cut_en_q;
    t0_d.limit = cut_lim_q;
    if (!req_i.req_type) begin
      t0_d.done = 1'b1;
      t0_d.err  = ok_a ? cpe_pkg::ERR_NONE : cpe_pkg::ERR_NOT_VALID;
    end else if (!ok_a || !ok_b) begin
      t0_d.done = 1'b1;
      t0_d.err  = cpe_pkg::ERR_NOT_VALID;
    end else if (req_i.dist_sq == '0 || (!ddm_sel && eps_sel == '0)) begin
      t0_d.done = 1'b1;
      t0_d.err  = cpe_pkg::ERR_BAD_ARG;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) t1_q <= '0;
    else         t1_q <= t0_d;
  end
  always_ff @(posedge clk_i) begin
    dsq1_q  <= req_i.dist_sq;
    eps1_q  <= eps_sel;
    ddm1_q  <= ddm_sel;
    pair1_q <= req_i.req_type && ok_a && ok_b;
  end

  // an unloaded entry outranks a bad distance or dielectric
  always_comb begin
    t1_fix = t1_q;
    if (pair1_q && !(ea_q[16] && eb_q[16])) begin
      t1_fix.done = 1'b1;
      t1_fix.err  = cpe_pkg::ERR_NOT_VALID;
    end
  end

  // ---------------- stage 1: charge product, root cell row in parallel
  logic signed [31:0] prod2_q;
  logic [31:0]        pmag;
  logic [31:0]        mag2_q;
  cpe_pkg::tag_t tg_q [RootLat+3];
  logic [23:0] dsqp_q [RootLat+3];
  logic [15:0] epsp_q [RootLat+3];
  logic        ddmp_q [RootLat+3];

  always_comb begin
    pmag = prod2_q[31] ? 32'(-prod2_q) : 32'(prod2_q);
  end

  always_ff @(posedge clk_i) begin
    prod2_q <= $signed(ea_q[15:0]) * $signed(eb_q[15:0]);
  end

  // tag line parallels the root cells; the sign joins at the second entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RootLat + 3; i++) tg_q[i] <= '0;
    end else begin
      tg_q[0] <= t1_fix;
      tg_q[1] <= {tg_q[0].vld, tg_q[0].done, tg_q[0].err, prod2_q[31], tg_q[0].clip,
                  tg_q[0].limit};
      for (int i = 2; i < RootLat + 3; i++) tg_q[i] <= tg_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    dsqp_q[0] <= dsq1_q;
    epsp_q[0] <= eps1_q;
    ddmp_q[0] <= ddm1_q;
    for (int i = 1; i < RootLat + 3; i++) begin
      dsqp_q[i] <= dsqp_q[i-1];
      epsp_q[i] <= epsp_q[i-1];
      ddmp_q[i] <= ddmp_q[i-1];
    end
  end

  // magnitude travels too; multiply by K once (fits 32x20)
  logic [51:0] nk_q [RootLat-3];
  always_ff @(posedge clk_i) begin
    mag2_q   <= pmag;
    nk_q[0]  <= {20'd0, mag2_q} * {32'd0, coulomb_k_q};
    for (int i = 1; i < RootLat - 3; i++) nk_q[i] <= nk_q[i-1];
  end

  // root cells on dsq << 12
  cpe_pkg::root_t rc [RootLat+1];
  assign rc[0] = '{rem: '0, root: '0, val: {dsq1_q, 12'd0}};
  for (genvar g = 0; g < RootLat; g++) begin : g_root
    cpe_root_cell u_cell (
      .clk_i  (clk_i),
      .in_i   (rc[g]),
      .pair_i (6'(RootLat - 1 - g)),
      .out_o  (rc[g+1])
    );
  end

  // ---------------- after root: divisor and numerator
  // root result aligns with tg_q[RootLat-1]; num_q aligns with div2_q
  logic [33:0] reps_q;
  logic [40:0] div_q;
  logic [65:0] num_q, num_d;
  logic [51:0] nk_a_q, nk_b_q;
  always_ff @(posedge clk_i) begin
    reps_q <= {16'd0, rc[RootLat].root} * {18'd0, epsp_q[RootLat-1]};
    nk_a_q <= nk_q[RootLat-4];
    div_q  <= ddmp_q[RootLat] ? {1'b0, dsqp_q[RootLat], 16'd0} : {1'b0, reps_q, 6'd0};
    nk_b_q <= nk_a_q;
  end
  // split 52x16 into two partial products
  logic [47:0] pl_q, ph_q;
  always_ff @(posedge clk_i) begin
    pl_q <= {16'd0, nk_b_q[31:0]} * {32'd0, scale_q};
    ph_q <= {28'd0, nk_b_q[51:32]} * {32'd0, scale_q};
  end
  logic [40:0] div2_q;
  always_ff @(posedge clk_i) div2_q <= div_q;
  always_comb num_d = {18'd0, pl_q} + {ph_q[33:0], 32'd0};

  cpe_pkg::div_t dc [cpe_pkg::DivSteps+1];
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end
  logic [cpe_pkg::RemWidth-1:0] rem0;
  logic [40:0] quo0;
  always_comb begin
    // upper 25 bits of numerator: quotient bits there only matter as overflow
    if ({17'd0, num_q[65:41]} >= {1'b0, div2_q}) begin
      quo0 = cpe_pkg::QuotCap;
      rem0 = '0;
    end else begin
      quo0 = '0;
      rem0 = {17'd0, num_q[65:41]};
    end
  end
  assign dc[0] = '{num: num_q, rem: rem0, quo: quo0, div: div2_q};
  for (genvar g = 0; g < cpe_pkg::DivSteps; g++) begin : g_div
    cpe_div_cell u_cell (
      .clk_i (clk_i),
      .in_i  (dc[g]),
      .bit_i (7'(cpe_pkg::DivSteps - 1 - g)),
      .out_o (dc[g+1])
    );
  end

  // tag line for the divider: tg_q last entry aligns with num_q
  localparam int unsigned TagDivLat = cpe_pkg::DivSteps;
  cpe_pkg::tag_t td_q [TagDivLat];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TagDivLat; i++) td_q[i] <= '0;
    end else begin
      td_q[0] <= tg_q[RootLat+2];
      for (int i = 1; i < TagDivLat; i++) td_q[i] <= td_q[i-1];
    end
  end

  // ---------------- output
  cpe_pkg::tag_t  tf;
  logic [40:0]    qf;
  logic signed [32:0] e_d;
  cpe_pkg::rsp_t  rsp_d;
  logic           done_q;
  cpe_pkg::rsp_t  rsp_q;

  assign tf = td_q[TagDivLat-1];
  assign qf = dc[cpe_pkg::DivSteps].quo;

  always_comb begin
    if (tf.neg) e_d = (qf >= 41'h8000_0000) ? -33'sh0_8000_0000 : -$signed({1'b0, qf[31:0]});
    else        e_d = (qf >= 41'h7FFF_FFFF) ? 33'sh0_7FFF_FFFF : $signed({1'b0, qf[31:0]});
    if (tf.clip && e_d > $signed({2'b00, tf.limit})) e_d = $signed({2'b00, tf.limit});
    rsp_d.energy     = tf.done ? '0 : e_d[31:0];
    rsp_d.error_code = tf.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_q <= 1'b0;
    else         done_q <= tf.vld;
  end
  always_ff @(posedge clk_i) rsp_q <= rsp_d;

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  `CPE_ASSERT_IMP(a_err_zero, clk_i, rst_ni, done_o && rsp_o.error_code != cpe_pkg::ERR_NONE, rsp_o.energy == '0)
  `CPE_ASSERT_IMP(a_err_code, clk_i, rst_ni, done_o, rsp_o.error_code <= cpe_pkg::ERR_BAD_ARG)
  `CPE_ASSERT_NXT(a_busy_low, clk_i, rst_ni, !busy, !busy)

endmodule
